// ----- src/svf_pkg.sv -----
// ----------------------------------------------------------------------------
// svf_pkg
// shared types, constants and helpers for the state-variable filter core
// ----------------------------------------------------------------------------
package svf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned StateW  = 24;
  localparam int unsigned QW      = 17;   // damping q, 0..32768
  localparam int unsigned FracW   = 15;   // q1.15 scaling

  // shared multiplier operand widths
  localparam int unsigned MulAW   = 18;
  localparam int unsigned MulBW   = 25;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned ShW     = ProdW - FracW;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 96;

  localparam logic [QW-1:0] QOne = QW'(32768);

  typedef enum logic [3:0] {
    S_IDLE,
    S_QQ,
    S_FB,
    S_QX,
    S_QQB,
    S_HI,
    S_FH,
    S_BP
  } svf_state_e;

  typedef enum logic [2:0] {
    OP_QQ,
    OP_FB,
    OP_QX,
    OP_QQB,
    OP_FH
  } svf_op_e;

  typedef struct packed {
    logic    mul_en;
    svf_op_e op_sel;
    logic    ld_qq;
    logic    ld_lo;
    logic    ld_qx;
    logic    ld_hi;
    logic    ld_out;
  } svf_ctrl_t;

  function automatic logic signed [StateW-1:0] sat24(input logic signed [31:0] v);
    logic signed [31:0] hi_lim;
    logic signed [31:0] lo_lim;
    hi_lim = 32'sd8388607;
    lo_lim = -32'sd8388608;
    if (v > hi_lim) begin
      sat24 = hi_lim[StateW-1:0];
    end else if (v < lo_lim) begin
      sat24 = lo_lim[StateW-1:0];
    end else begin
      sat24 = v[StateW-1:0];
    end
  endfunction

endpackage

// ----- src/svf_mul.sv -----
// ----------------------------------------------------------------------------
// svf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module svf_mul #(
  parameter int unsigned AW = svf_pkg::MulAW,
  parameter int unsigned BW = svf_pkg::MulBW
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  logic signed [AW+BW-1:0] p_q;
  logic signed [AW+BW-1:0] p_d;

  assign p_d = (AW+BW)'(a_i) * (AW+BW)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- src/svf_seq.sv -----
// ----------------------------------------------------------------------------
// svf_seq
// sequencer stepping one sample through the shared multiplier
// ----------------------------------------------------------------------------
module svf_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_busy_i,
  output logic                in_ready_o,
  output svf_pkg::svf_ctrl_t  ctrl_o
);

  svf_pkg::svf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      svf_pkg::S_IDLE: if (in_valid_i) state_d = svf_pkg::S_QQ;
      svf_pkg::S_QQ:   state_d = svf_pkg::S_FB;
      svf_pkg::S_FB:   state_d = svf_pkg::S_QX;
      svf_pkg::S_QX:   state_d = svf_pkg::S_QQB;
      svf_pkg::S_QQB:  state_d = svf_pkg::S_HI;
      svf_pkg::S_HI:   state_d = svf_pkg::S_FH;
      svf_pkg::S_FH:   state_d = svf_pkg::S_BP;
      svf_pkg::S_BP:   if (!out_busy_i) state_d = svf_pkg::S_IDLE;
      default:         state_d = svf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctrl_o        = '0;
    ctrl_o.op_sel = svf_pkg::OP_QQ;
    case (state_q)
      svf_pkg::S_IDLE: in_ready_o = 1'b1;
      svf_pkg::S_QQ: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = svf_pkg::OP_QQ;
      end
      svf_pkg::S_FB: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = svf_pkg::OP_FB;
        ctrl_o.ld_qq  = 1'b1;
      end
      svf_pkg::S_QX: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = svf_pkg::OP_QX;
        ctrl_o.ld_lo  = 1'b1;
      end
      svf_pkg::S_QQB: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = svf_pkg::OP_QQB;
        ctrl_o.ld_qx  = 1'b1;
      end
      svf_pkg::S_HI:   ctrl_o.ld_hi = 1'b1;
      svf_pkg::S_FH: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = svf_pkg::OP_FH;
      end
      svf_pkg::S_BP:   ctrl_o.ld_out = !out_busy_i;
      default:         in_ready_o = 1'b0;
    endcase
  end

endmodule

// ----- src/state_variable_filter_core.sv -----
// ----------------------------------------------------------------------------
// state_variable_filter_core
// two-pole resonant state-variable filter, fixed point, one sample per beat
// ----------------------------------------------------------------------------
// Each input beat carries a 16-bit sample, a q1.15 frequency coefficient f and
// a q1.15 resonance; damping is q = 1 - resonance (resonance clamped to one).
// The core runs low += f*band, high = q*x - low - q*q*band, band += f*high,
// notch = low + high, with products floored after the 15-bit shift and every
// sum saturated to 24 bits. Low and band persist between samples and clear on
// reset. All five products go through one shared 18x25 multiplier with a
// registered product, stepped by a small sequencer through its steps QQ, FB,
// QX, QQB, HI, FH and BP; a sample occupies the core from acceptance until the
// result register is loaded, and s_axis_tready is high only while the core
// is idle. A finished result waits in the output register and the next sample
// is taken meanwhile; the core only holds in its last step if the previous
// result has still not been taken.
module state_variable_filter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample [15:0], freq_coef [31:16], resonance [47:32]
  input  logic [svf_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // lowpass [23:0], bandpass [47:24], highpass [71:48], notch [95:72]
  output logic [svf_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready
);

  localparam int unsigned SW = svf_pkg::StateW;

  svf_pkg::svf_ctrl_t ctrl;
  logic               in_ready;
  logic               accept;
  logic               out_busy;

  // latched operands of the current sample
  logic signed [svf_pkg::SampleW-1:0] x_q;
  logic        [svf_pkg::CoefW-1:0]   f_q;
  logic        [svf_pkg::QW-1:0]      q_q;
  logic        [svf_pkg::QW-1:0]      q_d;
  logic        [svf_pkg::QW-1:0]      res_clamp;

  // filter state and intermediate results
  logic signed [SW-1:0] low_q, band_q;
  logic signed [SW-1:0] lo_q, hi_q;
  logic        [svf_pkg::QW-1:0] qq_q;
  logic signed [17:0]   qx_q;

  // shared multiplier
  logic signed [svf_pkg::MulAW-1:0] mul_a;
  logic signed [svf_pkg::MulBW-1:0] mul_b;
  logic signed [svf_pkg::ProdW-1:0] prod;
  logic signed [svf_pkg::ShW-1:0]   prod_sh;

  // output register
  logic                             out_valid_q, out_valid_d;
  logic [svf_pkg::OutDataW-1:0]     out_data_q;
  logic signed [SW-1:0]             bp_new, notch_new;

  assign accept   = s_axis_tvalid && in_ready;
  assign out_busy = out_valid_q && !m_axis_tready;

  svf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_busy),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl)
  );

  // clamp resonance to one, then damping q = 1 - resonance
  always_comb begin
    if (s_axis_tdata[47:32] > 16'd32768) begin
      res_clamp = svf_pkg::QOne;
    end else begin
      res_clamp = svf_pkg::QW'(s_axis_tdata[47:32]);
    end
    q_d = svf_pkg::QOne - res_clamp;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= $signed(s_axis_tdata[15:0]);
      f_q <= s_axis_tdata[31:16];
      q_q <= q_d;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.op_sel)
      svf_pkg::OP_QQ: begin
        mul_a = $signed({1'b0, q_q});
        mul_b = $signed(svf_pkg::MulBW'(q_q));
      end
      svf_pkg::OP_FB: begin
        mul_a = $signed(svf_pkg::MulAW'(f_q));
        mul_b = svf_pkg::MulBW'(band_q);
      end
      svf_pkg::OP_QX: begin
        mul_a = $signed({1'b0, q_q});
        mul_b = svf_pkg::MulBW'(x_q);
      end
      svf_pkg::OP_QQB: begin
        mul_a = $signed({1'b0, qq_q});
        mul_b = svf_pkg::MulBW'(band_q);
      end
      svf_pkg::OP_FH: begin
        mul_a = $signed(svf_pkg::MulAW'(f_q));
        mul_b = svf_pkg::MulBW'(hi_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  svf_mul #(
    .AW (svf_pkg::MulAW),
    .BW (svf_pkg::MulBW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // arithmetic shift floors the q1.15 product
  assign prod_sh = prod[svf_pkg::ProdW-1:svf_pkg::FracW];

  // intermediate results, each loaded in the sequencer step after its product
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_qq) begin
      qq_q <= prod_sh[svf_pkg::QW-1:0];
    end
    if (ctrl.ld_lo) begin
      lo_q <= svf_pkg::sat24(32'(low_q) + 32'(prod_sh));
    end
    if (ctrl.ld_qx) begin
      qx_q <= prod_sh[17:0];
    end
    if (ctrl.ld_hi) begin
      hi_q <= svf_pkg::sat24(32'(qx_q) - 32'(lo_q) - 32'(prod_sh));
    end
  end

  assign bp_new    = svf_pkg::sat24(32'(band_q) + 32'(prod_sh));
  assign notch_new = svf_pkg::sat24(32'(lo_q) + 32'(hi_q));

  // filter state, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      band_q <= '0;
    end else if (ctrl.ld_out) begin
      low_q  <= lo_q;
      band_q <= bp_new;
    end
  end

  // output register holds the result beat until it is taken
  assign out_valid_d = ctrl.ld_out || out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_out) begin
      out_data_q <= {notch_new, hi_q, bp_new, lo_q};
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- src/svf_checker.sv -----
// ----------------------------------------------------------------------------
// svf_checker
// port-level checks of the state-variable filter core, bound to the top level
// ----------------------------------------------------------------------------
module svf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [svf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // the core is not ready again right after it takes a sample
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("core ready again too soon after an input beat");

  // a new result appears only as the sequencer returns to idle
  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result beat raised while core still busy");

  // no result can follow an input beat within the next cycle
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result beat appeared without the full sequence");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed or dropped");

endmodule

bind state_variable_filter_core svf_checker u_svf_checker (.*);

// ----- verif/state_variable_filter_core_test.sv -----
// ----------------------------------------------------------------------------
// state_variable_filter_core_test
// self-checking bench for the state-variable filter core
// ----------------------------------------------------------------------------
// Drives sample beats through the slave stream and keeps a bit-true
// model of the filter alongside: low and band accumulators, floored q1.15
// products and 24-bit saturating sums. Every beat taken by the core pushes
// its predicted four-way response, and every beat leaving the master stream
// is compared field by field against the oldest prediction. Both stream sides
// pause at random, with one gap-free phase and one long output hold.
module state_variable_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles  = 300;   // long output hold-off
  localparam int StallLimit  = 2000;  // cycles without any beat before giving up
  localparam int SettleWait  = 16;    // extra wait after the last response, with slack
  localparam int IdlePercent = 26;

  // response fields, lowpass in the lowest bits
  typedef struct packed {
    logic signed [svf_pkg::StateW-1:0] notch;
    logic signed [svf_pkg::StateW-1:0] high;
    logic signed [svf_pkg::StateW-1:0] band;
    logic signed [svf_pkg::StateW-1:0] low;
  } svf_resp_t;

  logic                         clk_i  = 1'b0;
  logic                         rst_ni = 1'b0;
  logic [svf_pkg::InDataW-1:0]  s_data  = '0;
  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [svf_pkg::OutDataW-1:0] m_data;
  logic                         m_valid;
  logic                         m_ready = 1'b0;

  // model of the filter state
  longint low_acc  = 0;
  longint band_acc = 0;

  svf_resp_t pending_resp[$];
  int        fail_count  = 0;
  int        quiet_count = 0;
  bit        no_gaps  = 1'b0;
  bit        hold_req = 1'b0;

  state_variable_filter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready)
  );

  initial begin
    forever begin
      #1 clk_i = ~clk_i;
    end
  end

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  // one filter step; advances the model state and returns the response
  function automatic svf_resp_t advance_filter(input logic [svf_pkg::InDataW-1:0] beat);
    longint    x;
    longint    f;
    longint    res;
    longint    q;
    longint    qq;
    longint    lo;
    longint    hi;
    longint    bp;
    longint    nf;
    svf_resp_t r;
    x   = longint'($signed(beat[15:0]));
    f   = longint'(beat[31:16]);
    res = longint'(beat[47:32]);
    // resonance above one behaves as exactly one
    if (res > 32768) begin
      res = 32768;
    end
    q  = 32768 - res;
    qq = (q * q) >>> svf_pkg::FracW;
    // arithmetic shift of the signed product floors towards minus infinity
    lo = clamp24(low_acc + ((f * band_acc) >>> svf_pkg::FracW));
    hi = clamp24(((q * x) >>> svf_pkg::FracW) - lo
                 - ((qq * band_acc) >>> svf_pkg::FracW));
    bp = clamp24(band_acc + ((f * hi) >>> svf_pkg::FracW));
    nf = clamp24(lo + hi);
    low_acc  = lo;
    band_acc = bp;
    r.low   = lo[svf_pkg::StateW-1:0];
    r.band  = bp[svf_pkg::StateW-1:0];
    r.high  = hi[svf_pkg::StateW-1:0];
    r.notch = nf[svf_pkg::StateW-1:0];
    return r;
  endfunction

  function automatic logic [svf_pkg::InDataW-1:0] pack_beat(input int sample,
                                                            input int freq,
                                                            input int reso);
    logic [15:0] s16;
    logic [15:0] f16;
    logic [15:0] r16;
    s16 = sample[15:0];
    f16 = freq[15:0];
    r16 = reso[15:0];
    return {r16, f16, s16};
  endfunction

  // offer one beat, with a random lead-in gap, and hold until it is taken;
  // valid is left high so back-to-back beats never drop it
  task automatic send_beat(input logic [svf_pkg::InDataW-1:0] beat);
    if (!no_gaps) begin
      while ($urandom_range(99) < IdlePercent) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= beat;
    @(posedge clk_i);
    while (!s_ready) begin
      @(posedge clk_i);
    end
    pending_resp.push_back(advance_filter(beat));
  endtask

  // receiver: random readiness, or a counted hold when asked for
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        m_ready <= no_gaps || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // response checker
  always @(posedge clk_i) begin : check_resp
    svf_resp_t want;
    svf_resp_t got;
    string     field_name[4];
    field_name = '{"lowpass", "bandpass", "highpass", "notch"};
    if (rst_ni && m_valid && m_ready) begin
      got = svf_resp_t'(m_data);
      if (pending_resp.size() == 0) begin
        $display("%0t: response beat with none outstanding, data %h", $time, m_data);
        fail_count++;
      end else begin
        want = pending_resp.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (want[k*svf_pkg::StateW +: svf_pkg::StateW] !==
              got[k*svf_pkg::StateW +: svf_pkg::StateW]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name[k],
                     $signed(want[k*svf_pkg::StateW +: svf_pkg::StateW]),
                     $signed(got[k*svf_pkg::StateW +: svf_pkg::StateW]));
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on stream progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_count <= 0;
      end else begin
        quiet_count <= quiet_count + 1;
      end
      if (quiet_count >= StallLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // field extremes, clamped resonance, and a run at the largest f that
  // drives the state into saturation both ways
  task automatic test_directed();
    send_beat(pack_beat(0, 0, 0));
    send_beat(pack_beat(32767, 16384, 0));
    send_beat(pack_beat(0, 16384, 0));
    send_beat(pack_beat(0, 16384, 0));
    send_beat(pack_beat(-32768, 16384, 16384));
    send_beat(pack_beat(-32768, 65535, 32768));
    send_beat(pack_beat(32767, 8192, 32769));
    send_beat(pack_beat(1000, 8192, 65535));
    send_beat(pack_beat(-1, 1, 0));
    repeat (8) send_beat(pack_beat(32767, 65535, 0));
    repeat (5) send_beat(pack_beat(-32768, 65535, 0));
  endtask

  // runs of samples under one coefficient setting, with some pure noise runs
  task automatic test_random_streams(input int beats);
    int sent;
    int seg_len;
    int freq;
    int reso;
    int kind;
    int amp;
    int period;
    int sample;
    sent = 0;
    while (sent < beats) begin
      seg_len = $urandom_range(8, 60);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: freq = $urandom_range(1, 4000);
        6, 7:             freq = $urandom_range(0, 65535);
        8:                freq = $urandom_range(16384, 65535);
        default:          freq = 0;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6, 7: reso = $urandom_range(0, 32768);
        8:                      reso = 32768;
        default:                reso = $urandom_range(32769, 65535);
      endcase
      kind   = $urandom_range(4);
      amp    = (kind == 1) ? $urandom_range(1, 2000) : $urandom_range(1, 32767);
      period = $urandom_range(1, 12);
      for (int i = 0; i < seg_len; i++) begin
        case (kind)
          0:       sample = $urandom_range(0, 65535);
          1:       sample = $urandom_range(0, 2 * amp) - amp;
          2:       sample = ((i / period) % 2 == 0) ? amp : -amp - 1;
          3:       sample = (i == 0) ? amp : 0;
          default: begin
            // noise: every field changes each beat
            sample = $urandom_range(0, 65535);
            freq   = $urandom_range(0, 65535);
            reso   = $urandom_range(0, 65535);
          end
        endcase
        send_beat(pack_beat(sample, freq, reso));
      end
      sent += seg_len;
    end
  endtask

  // receiver holds off while beats keep coming, so the core backs up
  task automatic test_output_stall();
    hold_req = 1'b1;
    test_random_streams(60);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    test_random_streams(250);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_streams(1200);
    test_output_stall();
    test_back_to_back();
    s_valid <= 1'b0;
    while (pending_resp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
